// ----- rtl/rational_arithmetic_unit_macros.svh -----
// Assertion macros used by the rational arithmetic unit controller.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RAU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rau_pkg.sv -----
// Shared types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

   localparam int FIELD_W       = 32;
   localparam int RES_DEN_W     = 31;
   localparam int DEFAULT_WIDTH = 32;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic       capture;
      logic       load_a;
      logic       store_a_load_b;
      logic       store_b;
      logic       red_start;
      logic       gcd_step;
      logic       div_init;
      logic       div_step;
      logic       mul1;
      logic       mul2;
      logic       mul3;
      logic       combine;
      logic       out_load;
      status_type out_status;
   } dp_cmd_type;

   typedef struct packed {
      logic zero_den;
      logic num_zero;
      logic gcd_done;
      logic div_last;
      logic overflow;
      logic is_div;
   } dp_sts_type;

endpackage

// ----- rtl/rau_datapath.sv -----
// Datapath of the rational arithmetic unit: operands, gcd, divider, multiplier, result.
`timescale 1ns / 1ps
module rau_datapath #(
   parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
   input  logic                              clock,
   input  rau_pkg::dp_cmd_type               cmd,
   output rau_pkg::dp_sts_type               sts,
   input  logic [1:0]                        req_func,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_a_num,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_a_den,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_b_num,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_b_den,
   output logic signed [rau_pkg::FIELD_W-1:0] rsp_res_num,
   output logic [rau_pkg::RES_DEN_W-1:0]      rsp_res_den,
   output logic [1:0]                        rsp_status
);

   localparam int DW  = 2 * WIDTH + 1;
   localparam int KW  = $clog2(DW + 1);
   localparam int CW  = $clog2(DW);
   localparam int FW  = rau_pkg::FIELD_W;
   localparam int RDW = rau_pkg::RES_DEN_W;
   localparam logic [DW-1:0] LIMIT = {{(DW-WIDTH+1){1'b0}}, {(WIDTH-1){1'b1}}};
   localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);

   rau_pkg::func_type func_ff;
   logic              a_neg_ff, b_neg_ff, r_neg_ff;
   logic [WIDTH-1:0]  an_ff, ad_ff, bn_ff, bd_ff;
   logic [DW-1:0]     pn_ff, pd_ff;
   logic [DW-1:0]     x_ff, y_ff, g_ff;
   logic [KW-1:0]     k_ff;
   logic [DW-1:0]     rn_ff, rd_ff;
   logic [CW-1:0]     cnt_ff;
   logic [2*WIDTH-1:0] p1_ff, p2_ff;

   logic [WIDTH-1:0]  raw_an, raw_ad, raw_bn, raw_bd;
   logic [WIDTH-1:0]  mag_an, mag_ad, mag_bn, mag_bd;
   logic [WIDTH-1:0]  mul_x, mul_y;
   logic [2*WIDTH-1:0] prod;
   logic [DW:0]       rn_sh, rd_sh, g_ext;
   logic              n_ge, d_ge;
   logic [DW-1:0]     e1, e2;
   logic              s1, s2;
   logic [FW-1:0]     res_mag;

   assign raw_an = req_a_num[WIDTH-1:0];
   assign raw_ad = req_a_den[WIDTH-1:0];
   assign raw_bn = req_b_num[WIDTH-1:0];
   assign raw_bd = req_b_den[WIDTH-1:0];
   assign mag_an = raw_an[WIDTH-1] ? (~raw_an + 1'b1) : raw_an;
   assign mag_ad = raw_ad[WIDTH-1] ? (~raw_ad + 1'b1) : raw_ad;
   assign mag_bn = raw_bn[WIDTH-1] ? (~raw_bn + 1'b1) : raw_bn;
   assign mag_bd = raw_bd[WIDTH-1] ? (~raw_bd + 1'b1) : raw_bd;

   // One shared multiplier, stepped through the three products.
   always_comb begin
      mul_x = an_ff;
      mul_y = (func_ff == rau_pkg::FUNC_MUL) ? bn_ff : bd_ff;
      if (cmd.mul2) begin
         mul_x = bn_ff;
         mul_y = ad_ff;
      end else if (cmd.mul3) begin
         mul_x = ad_ff;
         mul_y = (func_ff == rau_pkg::FUNC_DIV) ? bn_ff : bd_ff;
      end
   end
   assign prod = mul_x * mul_y;

   assign g_ext = {1'b0, g_ff};
   assign rn_sh = {rn_ff, pn_ff[DW-1]};
   assign rd_sh = {rd_ff, pd_ff[DW-1]};
   assign n_ge  = rn_sh >= g_ext;
   assign d_ge  = rd_sh >= g_ext;

   assign e1 = DW'(p1_ff);
   assign e2 = DW'(p2_ff);
   assign s1 = a_neg_ff;
   assign s2 = b_neg_ff ^ (func_ff == rau_pkg::FUNC_SUB);

   assign res_mag = FW'(pn_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= rau_pkg::func_type'(req_func);
         a_neg_ff <= raw_an[WIDTH-1] ^ raw_ad[WIDTH-1];
         b_neg_ff <= raw_bn[WIDTH-1] ^ raw_bd[WIDTH-1];
         an_ff    <= mag_an;
         ad_ff    <= mag_ad;
         bn_ff    <= mag_bn;
         bd_ff    <= mag_bd;
      end
      if (cmd.load_a) begin
         pn_ff <= DW'(an_ff);
         pd_ff <= DW'(ad_ff);
      end
      if (cmd.store_a_load_b) begin
         an_ff <= pn_ff[WIDTH-1:0];
         ad_ff <= pd_ff[WIDTH-1:0];
         pn_ff <= DW'(bn_ff);
         pd_ff <= DW'(bd_ff);
      end
      if (cmd.store_b) begin
         bn_ff <= pn_ff[WIDTH-1:0];
         bd_ff <= pd_ff[WIDTH-1:0];
      end
      if (cmd.red_start) begin
         if (pn_ff == '0) begin
            pd_ff <= DW'(1);
         end else begin
            x_ff <= pn_ff;
            y_ff <= pd_ff;
            k_ff <= '0;
         end
      end
      // Binary gcd: strip common factors of two, then subtract odd from odd.
      if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_ff <= x_ff >> 1;
            y_ff <= y_ff >> 1;
            k_ff <= k_ff + KW'(1);
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_ff <= x_ff - y_ff;
         end else begin
            y_ff <= y_ff - x_ff;
         end
      end
      if (cmd.div_init) begin
         g_ff   <= (x_ff | y_ff) << k_ff;
         rn_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end
      // Restoring division of both numerator and denominator by the gcd.
      if (cmd.div_step) begin
         rn_ff  <= n_ge ? DW'(rn_sh - g_ext) : DW'(rn_sh);
         rd_ff  <= d_ge ? DW'(rd_sh - g_ext) : DW'(rd_sh);
         pn_ff  <= {pn_ff[DW-2:0], n_ge};
         pd_ff  <= {pd_ff[DW-2:0], d_ge};
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.mul1) begin
         p1_ff <= prod;
      end
      if (cmd.mul2) begin
         p2_ff <= prod;
      end
      if (cmd.mul3) begin
         pd_ff <= DW'(prod);
      end
      if (cmd.combine) begin
         if (func_ff == rau_pkg::FUNC_MUL || func_ff == rau_pkg::FUNC_DIV) begin
            pn_ff    <= e1;
            r_neg_ff <= a_neg_ff ^ b_neg_ff;
         end else if (s1 == s2) begin
            pn_ff    <= e1 + e2;
            r_neg_ff <= s1;
         end else if (e1 >= e2) begin
            pn_ff    <= e1 - e2;
            r_neg_ff <= s1;
         end else begin
            pn_ff    <= e2 - e1;
            r_neg_ff <= s2;
         end
      end
      if (cmd.out_load) begin
         rsp_status <= cmd.out_status;
         if (cmd.out_status == rau_pkg::ST_OK) begin
            rsp_res_num <= (r_neg_ff && pn_ff != '0) ? -res_mag : res_mag;
            rsp_res_den <= RDW'(pd_ff);
         end else begin
            rsp_res_num <= '0;
            rsp_res_den <= RDW'(1);
         end
      end
   end

   assign sts.zero_den = (ad_ff == '0) || (bd_ff == '0);
   assign sts.num_zero = (pn_ff == '0);
   assign sts.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign sts.div_last = (cnt_ff == DIV_LAST);
   assign sts.overflow = (pn_ff > LIMIT) || (pd_ff > LIMIT);
   assign sts.is_div   = (func_ff == rau_pkg::FUNC_DIV);

endmodule

// ----- rtl/rau_controller.sv -----
// Sequencing state machine of the rational arithmetic unit.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_macros.svh"
module rau_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rau_pkg::dp_cmd_type cmd,
   input  rau_pkg::dp_sts_type sts
);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_CHECK = 11'b00000000010,
      S_RED   = 11'b00000000100,
      S_GCD   = 11'b00000001000,
      S_DIV   = 11'b00000010000,
      S_STORE = 11'b00000100000,
      S_MUL1  = 11'b00001000000,
      S_MUL2  = 11'b00010000000,
      S_MUL3  = 11'b00100000000,
      S_COMB  = 11'b01000000000,
      S_FIN   = 11'b10000000000
   } state_type;

   typedef enum logic [1:0] {
      PH_A   = 2'd0,
      PH_B   = 2'd1,
      PH_RES = 2'd2
   } phase_type;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   rau_pkg::status_type  status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.out_status = status_ff;
      state_in     = state_ff;
      phase_in     = phase_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.zero_den) begin
               status_in = rau_pkg::ST_ZERO_DEN;
               state_in  = S_FIN;
            end else begin
               cmd.load_a = 1'b1;
               phase_in   = PH_A;
               state_in   = S_RED;
            end
         end
         S_RED: begin
            cmd.red_start = 1'b1;
            state_in      = sts.num_zero ? S_STORE : S_GCD;
         end
         S_GCD: begin
            if (sts.gcd_done) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            case (phase_ff)
               PH_A: begin
                  cmd.store_a_load_b = 1'b1;
                  phase_in           = PH_B;
                  state_in           = S_RED;
               end
               PH_B: begin
                  cmd.store_b = 1'b1;
                  if (sts.is_div && sts.num_zero) begin
                     status_in = rau_pkg::ST_DIV_ZERO;
                     state_in  = S_FIN;
                  end else begin
                     state_in = S_MUL1;
                  end
               end
               default: begin
                  status_in = sts.overflow ? rau_pkg::ST_OVERFLOW : rau_pkg::ST_OK;
                  state_in  = S_FIN;
               end
            endcase
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = S_COMB;
         end
         S_COMB: begin
            cmd.combine = 1'b1;
            phase_in    = PH_RES;
            state_in    = S_RED;
         end
         S_FIN: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = rau_pkg::ST_OK;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_A;
         status_ff    <= rau_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RAU_ASSERT_NEXT(a_accept_to_check, clock, reset, req_valid && req_ready, state_ff == S_CHECK, "accepted transaction did not start the check step")
   `RAU_ASSERT_NEXT(a_fin_delivers, clock, reset, state_ff == S_FIN && slot_free, rsp_valid_ff && state_ff == S_IDLE, "finished result was not posted")
   `RAU_ASSERT_NEXT(a_div_ends, clock, reset, state_ff == S_DIV && sts.div_last, state_ff == S_STORE, "divider did not hand over after its last step")
   `RAU_ASSERT_NOW(a_busy_not_ready, clock, reset, state_ff != S_IDLE, !req_ready, "input accepted while busy")

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit.
`timescale 1ns / 1ps
// The unit takes one transaction of two signed fractions and an operation
// code (add, subtract, multiply, divide) and returns one reduced fraction
// with a status code. Only the low WIDTH bits of each operand are used, as
// two's complement values. Each operand is reduced with a binary gcd and a
// restoring divider, the cross products are formed exactly by one shared
// WIDTH by WIDTH multiplier, and the result is reduced the same way. A zero
// operand denominator, division by a zero fraction, or a reduced result that
// does not fit in WIDTH-1 magnitude bits returns 0/1 with a nonzero status.
// One transaction is worked on at a time. Each of the three reductions runs
// the bit-serial gcd, one step per cycle, and then the bit-serial restoring
// divider, with sequencing steps on top. A zero numerator skips its gcd and
// division, and a zero operand denominator finishes the transaction without
// any reduction.
// The result sits in an output register, so the next transaction may be
// accepted and computed while the previous result waits to be taken.
module rational_arithmetic_unit #(
   parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_func,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_a_num,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_a_den,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_b_num,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_b_den,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [rau_pkg::FIELD_W-1:0] rsp_res_num,
   output logic [rau_pkg::RES_DEN_W-1:0]      rsp_res_den,
   output logic [1:0]                         rsp_status
);

   // Commands from the state machine to the datapath and status back.
   rau_pkg::dp_cmd_type cmd;
   rau_pkg::dp_sts_type sts;

   rau_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rau_datapath #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .sts         (sts),
      .req_func    (req_func),
      .req_a_num   (req_a_num),
      .req_a_den   (req_a_den),
      .req_b_num   (req_b_num),
      .req_b_den   (req_b_den),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den),
      .rsp_status  (rsp_status)
   );

endmodule

// ----- sim/rau_checker.sv -----
// Checker for the rational arithmetic unit: predicts each result and compares it.
`timescale 1ns / 1ps
module rau_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [1:0]                     req_func,
   input  logic [rau_pkg::FIELD_W-1:0]    req_a_num,
   input  logic [rau_pkg::FIELD_W-1:0]    req_a_den,
   input  logic [rau_pkg::FIELD_W-1:0]    req_b_num,
   input  logic [rau_pkg::FIELD_W-1:0]    req_b_den,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [rau_pkg::FIELD_W-1:0]    rsp_res_num,
   input  logic [rau_pkg::RES_DEN_W-1:0]  rsp_res_den,
   input  logic [1:0]                     rsp_status,
   output int                             fail_count,
   output int                             pending
);

   typedef struct {
      logic [rau_pkg::FIELD_W-1:0]   num;
      logic [rau_pkg::RES_DEN_W-1:0] den;
      rau_pkg::status_type           status;
   } fraction_type;

   localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF;

   fraction_type expected_fractions[$];
   int           fail_total = 0;

   function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // Bring n/d to lowest terms with the sign on the numerator; zero becomes 0/1.
   function automatic void reduce_fraction(inout logic n_neg, inout logic [63:0] n_mag,
                                           inout logic d_neg, inout logic [63:0] d_mag);
      logic [63:0] g;
      if (n_mag == 0) begin
         n_neg = 1'b0;
         d_mag = 64'd1;
      end else begin
         g     = euclid_gcd(n_mag, d_mag);
         n_mag = n_mag / g;
         d_mag = d_mag / g;
         n_neg = n_neg ^ d_neg;
      end
      d_neg = 1'b0;
   endfunction

   function automatic fraction_type predict_fraction(rau_pkg::func_type op,
                                                     logic [31:0] an_raw,
                                                     logic [31:0] ad_raw,
                                                     logic [31:0] bn_raw,
                                                     logic [31:0] bd_raw);
      logic         an_s, ad_s, bn_s, bd_s, rn_s, rd_s, p_s, t_s;
      logic [63:0]  an_m, ad_m, bn_m, bd_m, rn_m, rd_m, p_m, t_m;
      fraction_type r;
      r.num = '0;
      r.den = 31'd1;
      r.status = rau_pkg::ST_OK;
      // Magnitudes are taken at 32 bits, so the most negative value maps to 2^31.
      an_s = an_raw[31]; an_m = {32'd0, an_s ? ~an_raw + 32'd1 : an_raw};
      ad_s = ad_raw[31]; ad_m = {32'd0, ad_s ? ~ad_raw + 32'd1 : ad_raw};
      bn_s = bn_raw[31]; bn_m = {32'd0, bn_s ? ~bn_raw + 32'd1 : bn_raw};
      bd_s = bd_raw[31]; bd_m = {32'd0, bd_s ? ~bd_raw + 32'd1 : bd_raw};
      if (ad_m == 0 || bd_m == 0) begin
         r.status = rau_pkg::ST_ZERO_DEN;
         return r;
      end
      reduce_fraction(an_s, an_m, ad_s, ad_m);
      reduce_fraction(bn_s, bn_m, bd_s, bd_m);
      if (op == rau_pkg::FUNC_DIV && bn_m == 0) begin
         r.status = rau_pkg::ST_DIV_ZERO;
         return r;
      end
      rd_s = 1'b0;
      case (op)
         rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
            p_m = an_m * bd_m;
            p_s = an_s && p_m != 0;
            t_m = bn_m * ad_m;
            t_s = bn_s && t_m != 0;
            if (op == rau_pkg::FUNC_SUB && t_m != 0) t_s = !t_s;
            if (p_s == t_s) begin
               rn_m = p_m + t_m;
               rn_s = p_s;
            end else if (p_m >= t_m) begin
               rn_m = p_m - t_m;
               rn_s = p_s;
            end else begin
               rn_m = t_m - p_m;
               rn_s = t_s;
            end
            rd_m = ad_m * bd_m;
         end
         rau_pkg::FUNC_MUL: begin
            rn_m = an_m * bn_m;
            rn_s = an_s ^ bn_s;
            rd_m = ad_m * bd_m;
         end
         default: begin
            rn_m = an_m * bd_m;
            rn_s = an_s;
            rd_m = ad_m * bn_m;
            rd_s = bn_s;
         end
      endcase
      reduce_fraction(rn_s, rn_m, rd_s, rd_m);
      if (rn_m > MAG_LIMIT || rd_m > MAG_LIMIT) begin
         r.status = rau_pkg::ST_OVERFLOW;
         return r;
      end
      r.num = rn_s ? ~rn_m[31:0] + 32'd1 : rn_m[31:0];
      r.den = rd_m[30:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      fail_total++;
   endtask

   assign pending    = expected_fractions.size();
   assign fail_count = fail_total;

   always @(posedge clock) begin
      fraction_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_fractions.push_back(predict_fraction(rau_pkg::func_type'(req_func),
                                         req_a_num, req_a_den, req_b_num, req_b_den));
         if (rsp_valid && rsp_ready) begin
            if (expected_fractions.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_res_num !== want.num)
                  report_mismatch("res_num", $signed(rsp_res_num), $signed(want.num));
               if (rsp_res_den !== want.den)
                  report_mismatch("res_den", rsp_res_den, want.den);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
         end
      end
   end

endmodule

// ----- sim/tb_top.sv -----
// Top of the rational arithmetic unit testbench: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_top;

   // Generous cycle budget for the whole run.
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int RANDOM_ITEMS = 650;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [1:0]                          req_func = '0;
   logic signed [rau_pkg::FIELD_W-1:0]  req_a_num = '0;
   logic signed [rau_pkg::FIELD_W-1:0]  req_a_den = '0;
   logic signed [rau_pkg::FIELD_W-1:0]  req_b_num = '0;
   logic signed [rau_pkg::FIELD_W-1:0]  req_b_den = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [rau_pkg::FIELD_W-1:0]  rsp_res_num;
   logic [rau_pkg::RES_DEN_W-1:0]       rsp_res_den;
   logic [1:0]                          rsp_status;
   int                                  fail_count;
   int                                  pending;

   // Idle percentages for each side, and a request for one long hold-off of the
   // receiver; the receiver process counts the hold-off itself.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int recv_hold_cycles = 0;
   int cycle_count = 0;

   always #6 clock = ~clock;

   rational_arithmetic_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_a_num  (req_a_num),
      .req_a_den  (req_a_den),
      .req_b_num  (req_b_num),
      .req_b_den  (req_b_den),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_res_num(rsp_res_num),
      .rsp_res_den(rsp_res_den),
      .rsp_status (rsp_status)
   );

   rau_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_a_num  (req_a_num),
      .req_a_den  (req_a_den),
      .req_b_num  (req_b_num),
      .req_b_den  (req_b_den),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_res_num(rsp_res_num),
      .rsp_res_den(rsp_res_den),
      .rsp_status (rsp_status),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // The run is ended here if the block stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[rational_arithmetic_unit] ERROR");
         $finish;
      end
   end

   // Result side: a long hold-off takes priority; otherwise ready drops at random.
   always @(negedge clock) begin
      if (hold_request && !hold_done) begin
         hold_done        = 1'b1;
         recv_hold_cycles = 3000;
      end
      if (recv_hold_cycles > 0) begin
         recv_hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one transaction, after the random idle gaps, and hold it until accepted.
   // Each falling edge carries at most one assignment to valid.
   task automatic send_fraction_pair(rau_pkg::func_type op, logic [31:0] an,
                                     logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_func  <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      do @(posedge clock); while (!req_ready);
   endtask

   // Operand values weighted toward the interesting corners, with full-range
   // values often enough that every bit is exercised.
   function automatic logic [31:0] pick_operand(bit allow_zero);
      case ($urandom_range(9))
         0:       return allow_zero ? 32'd0 : 32'd1;
         1:       return 32'h8000_0000;
         2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0001;
         3, 4, 5: return 32'($signed($urandom_range(200)) - 100) | (allow_zero ? 0 : 1);
         6, 7:    return {{16{1'b0}}, 16'($urandom)} * ($urandom_range(1) ? 1 : -1) | 1;
         default: return $urandom;
      endcase
   endfunction

   // Random transactions: mostly well-formed operands, with zero denominators
   // and zero divisors mixed in now and then.
   task automatic send_random_items(int count);
      logic [31:0] ad, bd;
      repeat (count) begin
         ad = ($urandom_range(24) == 0) ? 32'd0 : pick_operand(1'b0);
         bd = ($urandom_range(24) == 0) ? 32'd0 : pick_operand(1'b0);
         send_fraction_pair(rau_pkg::func_type'($urandom_range(3)), pick_operand(1'b1),
                            ad, pick_operand(1'b1), bd);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corners: each operation, each error code, the most negative
      // operand, negative denominators and results that just overflow.
      send_fraction_pair(rau_pkg::FUNC_ADD, 1, 2, 1, 3);
      send_fraction_pair(rau_pkg::FUNC_SUB, 3, 4, 6, 8);
      send_fraction_pair(rau_pkg::FUNC_MUL, -2, 3, 9, -4);
      send_fraction_pair(rau_pkg::FUNC_DIV, 5, -7, -10, 21);
      send_fraction_pair(rau_pkg::FUNC_ADD, 0, -5, 0, 9);
      send_fraction_pair(rau_pkg::FUNC_ADD, 1, 0, 1, 1);
      send_fraction_pair(rau_pkg::FUNC_MUL, 1, 1, 1, 0);
      send_fraction_pair(rau_pkg::FUNC_DIV, 1, 0, 0, 1);
      send_fraction_pair(rau_pkg::FUNC_DIV, 4, 5, 0, -3);
      send_fraction_pair(rau_pkg::FUNC_MUL, 32'h8000_0000, 1, 1, 1);
      send_fraction_pair(rau_pkg::FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 1, 1);
      send_fraction_pair(rau_pkg::FUNC_MUL, 32'h8000_0000, 2, 1, 1);
      send_fraction_pair(rau_pkg::FUNC_MUL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
      send_fraction_pair(rau_pkg::FUNC_DIV, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
      send_fraction_pair(rau_pkg::FUNC_ADD, 32'h7FFF_FFFF, 1, 32'h8000_0001, 1);
      send_fraction_pair(rau_pkg::FUNC_SUB, 32'h7FFF_FFFF, 1, -1, 1);
      send_fraction_pair(rau_pkg::FUNC_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000);
      send_fraction_pair(rau_pkg::FUNC_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      send_fraction_pair(rau_pkg::FUNC_DIV, 1000000, 999999, 999999, 1000000);

      // Sender sparse, receiver busy; a long receiver hold-off partway in
      // lets the output register fill so the block must stall its input.
      send_idle_pct = 29;
      recv_idle_pct = 55;
      send_random_items(RANDOM_ITEMS / 6);
      hold_request = 1'b1;
      send_random_items(RANDOM_ITEMS / 6);

      send_idle_pct = 55;
      recv_idle_pct = 29;
      send_random_items(RANDOM_ITEMS / 3);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_items(RANDOM_ITEMS / 3);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (500) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("[rational_arithmetic_unit] OK");
      else
         $display("[rational_arithmetic_unit] ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_datapath.sv
rtl/rau_controller.sv
rtl/rational_arithmetic_unit.sv
sim/rau_checker.sv
sim/tb_top.sv
